/* rtl/tduf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tduf_pkg
// Types and constants shared by the three-domain union-find checker.
// ----------------------------------------------------------------------------
package tduf_pkg;

    // width of the clamped item limit, holds any item count up to 65536
    localparam int LIMIT_W = 17;

    localparam logic [1:0] DOM_SAME = 2'd0;
    localparam logic [1:0] DOM_PREY = 2'd1;
    localparam logic [1:0] DOM_PRED = 2'd2;

    localparam logic CMD_SAME = 1'b0;
    localparam logic CMD_EATS = 1'b1;

    localparam logic [2:0] STEP_FIRST      = 3'd0;
    localparam logic [2:0] STEP_LAST_CHK_S = 3'd3;
    localparam logic [2:0] STEP_LAST_CHK_E = 3'd2;
    localparam logic [2:0] STEP_FIRST_JOIN = 3'd4;
    localparam logic [2:0] STEP_LAST       = 3'd6;

    typedef struct packed {
        logic        command;
        logic [15:0] animal_a;
        logic [15:0] animal_b;
    } in_t;

    typedef struct packed {
        logic        is_false;
        logic [31:0] false_count;
    } out_t;

    // classified statement handed from front to back
    typedef struct packed {
        logic        pre_bad;
        logic        command;
        logic [15:0] a_idx;
        logic [15:0] b_idx;
    } entry_t;

    // one slot operand: which item and which domain
    typedef struct packed {
        logic       item_b;
        logic [1:0] dom;
    } op_t;

    typedef struct packed {
        op_t x;
        op_t y;
    } step_ops_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_ISSUE,
        ST_FIND_CHECK,
        ST_RESULT
    } back_state_t;

    localparam op_t OP_AS = '{item_b: 1'b0, dom: DOM_SAME};
    localparam op_t OP_AP = '{item_b: 1'b0, dom: DOM_PREY};
    localparam op_t OP_AE = '{item_b: 1'b0, dom: DOM_PRED};
    localparam op_t OP_BS = '{item_b: 1'b1, dom: DOM_SAME};
    localparam op_t OP_BP = '{item_b: 1'b1, dom: DOM_PREY};
    localparam op_t OP_BE = '{item_b: 1'b1, dom: DOM_PRED};

    // slot pair for each step: checks first, then the three joins
    function automatic step_ops_t step_ops(logic cmd, logic [2:0] step);
        step_ops_t r;
        r = '{x: OP_AS, y: OP_BS};
        case ({cmd, step})
            {CMD_SAME, 3'd0}: r = '{x: OP_AP, y: OP_BS};
            {CMD_SAME, 3'd1}: r = '{x: OP_AE, y: OP_BS};
            {CMD_SAME, 3'd2}: r = '{x: OP_BP, y: OP_AS};
            {CMD_SAME, 3'd3}: r = '{x: OP_BE, y: OP_AS};
            {CMD_SAME, 3'd4}: r = '{x: OP_AS, y: OP_BS};
            {CMD_SAME, 3'd5}: r = '{x: OP_AP, y: OP_BP};
            {CMD_SAME, 3'd6}: r = '{x: OP_AE, y: OP_BE};
            {CMD_EATS, 3'd0}: r = '{x: OP_AS, y: OP_BS};
            {CMD_EATS, 3'd1}: r = '{x: OP_AE, y: OP_BS};
            {CMD_EATS, 3'd2}: r = '{x: OP_BP, y: OP_AS};
            {CMD_EATS, 3'd4}: r = '{x: OP_AP, y: OP_BS};
            {CMD_EATS, 3'd5}: r = '{x: OP_AS, y: OP_BE};
            {CMD_EATS, 3'd6}: r = '{x: OP_AE, y: OP_BP};
            default:          r = '{x: OP_AS, y: OP_BS};
        endcase
        return r;
    endfunction

endpackage

/* rtl/three_domain_union_find_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_domain_union_find_checker
// Flags false "same kind" / "eats" statements against a union-find table.
// ----------------------------------------------------------------------------
// Statements come in on the s_ valid/ready channel, one word per statement;
// each gives one result word on the m_ channel: the false flag and the
// saturating count of false statements so far. cfg_we/cfg_wdata set the
// number of items in use; write it only while the block is idle.
// After reset the parent table is cleared one slot a cycle; s_ready stays
// low until that is done. A front stage range-checks each statement and
// parks it in a two-entry queue; the back walks the table one statement at
// a time. Each find issues and checks one table read per hop plus one for
// the root, up to 14 finds per statement; out-of-range and self-eating
// statements skip the finds and go straight to the result. The single table
// read port sets this pace. A result waits in the output register while
// m_ready is low; the back then holds its next result, the queue fills, and
// s_ready drops.
// ----------------------------------------------------------------------------
module three_domain_union_find_checker #(
    parameter int MAX_ANIMALS = 4096
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tduf_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tduf_pkg::out_t  m_data,
    input  logic            cfg_we,
    input  logic [12:0]     cfg_wdata
);
    import tduf_pkg::*;

    localparam logic [LIMIT_W-1:0] MAX_W = LIMIT_W'(MAX_ANIMALS);

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic               init_done;
    logic               push;
    entry_t             push_entry;
    logic               q_ready;
    logic               q_valid;
    entry_t             q_entry;
    logic               pop;

    // item count clamped to the table size
    always_comb begin
        limit_next = limit_reg;
        if (cfg_we) begin
            limit_next = ({4'd0, cfg_wdata} > MAX_W) ? MAX_W : {4'd0, cfg_wdata};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= MAX_W;
        end else begin
            limit_reg <= limit_next;
        end
    end

    tduf_front u_front (
        .init_done  (init_done),
        .limit      (limit_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready)
    );

    tduf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    tduf_back #(
        .MAX_ANIMALS (MAX_ANIMALS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* rtl/tduf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tduf_front
// Accepts statements, range-checks the items and flags self-eating.
// ----------------------------------------------------------------------------
module tduf_front (
    input  logic                        init_done,
    input  logic [tduf_pkg::LIMIT_W-1:0] limit,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tduf_pkg::in_t               s_data,
    output logic                        push,
    output tduf_pkg::entry_t            push_entry,
    input  logic                        q_ready
);
    import tduf_pkg::*;

    logic a_bad;
    logic b_bad;
    logic self_eat;

    // no words taken until the table is cleared
    assign s_ready = q_ready && init_done;
    assign push    = s_valid && s_ready;

    assign a_bad    = (s_data.animal_a == 16'd0) ||
                      ({1'b0, s_data.animal_a} > limit);
    assign b_bad    = (s_data.animal_b == 16'd0) ||
                      ({1'b0, s_data.animal_b} > limit);
    assign self_eat = (s_data.command == CMD_EATS) &&
                      (s_data.animal_a == s_data.animal_b);

    always_comb begin
        push_entry.pre_bad = a_bad || b_bad || self_eat;
        push_entry.command = s_data.command;
        push_entry.a_idx   = s_data.animal_a - 16'd1;
        push_entry.b_idx   = s_data.animal_b - 16'd1;
    end

endmodule

/* rtl/tduf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tduf_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module tduf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tduf_pkg::entry_t push_entry,
    output logic             q_ready,
    output logic             q_valid,
    output tduf_pkg::entry_t q_entry,
    input  logic             pop
);
    import tduf_pkg::*;

    entry_t     slots_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/tduf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tduf_back
// Holds the parent table, walks finds, does the checks and the joins,
// and keeps the saturating count of false statements.
// ----------------------------------------------------------------------------
module tduf_back #(
    parameter int MAX_ANIMALS = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    output logic             init_done,
    input  logic             q_valid,
    input  tduf_pkg::entry_t q_entry,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output tduf_pkg::out_t   m_data
);
    import tduf_pkg::*;

    localparam int SLOTS = 3 * MAX_ANIMALS;
    localparam int SW    = $clog2(SLOTS);
    localparam logic [SW-1:0] BASE_PREY = SW'(MAX_ANIMALS);
    localparam logic [SW-1:0] BASE_PRED = SW'(2 * MAX_ANIMALS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    logic [SW-1:0] mem [SLOTS];

    back_state_t   state_reg,  state_next;
    logic [2:0]    step_reg,   step_next;
    logic          which_reg,  which_next;
    logic [SW-1:0] cur_reg,    cur_next;
    logic [SW-1:0] rx_reg,     rx_next;
    logic          bad_reg,    bad_next;
    logic [SW-1:0] clr_reg,    clr_next;
    logic [31:0]   count_reg,  count_next;
    logic          m_valid_reg, m_valid_next;
    out_t          m_data_reg, m_data_next;
    entry_t        entry_reg,  entry_next;
    logic [SW-1:0] rdata_reg;
    logic          we;
    logic [SW-1:0] waddr;
    logic [SW-1:0] wdata;
    logic [2:0]    step_after;
    logic          step_done;
    step_ops_t     ops_cur;
    step_ops_t     ops_after;
    step_ops_t     ops_first;

    function automatic logic [SW-1:0] slot_of(op_t op, entry_t e);
        logic [SW-1:0] base;
        logic [SW-1:0] idx;
        idx = op.item_b ? SW'(e.b_idx) : SW'(e.a_idx);
        case (op.dom)
            DOM_PREY: base = BASE_PREY;
            DOM_PRED: base = BASE_PRED;
            default:  base = '0;
        endcase
        return base + idx;
    endfunction

    assign init_done = (state_reg != ST_CLEAR);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign ops_cur   = step_ops(entry_reg.command, step_reg);
    assign ops_after = step_ops(entry_reg.command, step_after);
    assign ops_first = step_ops(q_entry.command, STEP_FIRST);

    // next step: eats skips the fourth check, last join ends the statement
    always_comb begin
        step_done  = (step_reg == STEP_LAST);
        step_after = step_reg + 3'd1;
        if (entry_reg.command == CMD_EATS && step_reg == STEP_LAST_CHK_E) begin
            step_after = STEP_FIRST_JOIN;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        which_next   = which_reg;
        cur_next     = cur_reg;
        rx_next      = rx_reg;
        bad_next     = bad_reg;
        clr_next     = clr_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        entry_next   = entry_reg;
        pop          = 1'b0;
        we           = 1'b0;
        waddr        = clr_reg;
        wdata        = clr_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    pop        = 1'b1;
                    entry_next = q_entry;
                    step_next  = STEP_FIRST;
                    which_next = 1'b0;
                    bad_next   = q_entry.pre_bad;
                    cur_next   = slot_of(ops_first.x, q_entry);
                    state_next = q_entry.pre_bad ? ST_RESULT : ST_FIND_ISSUE;
                end
            end
            ST_FIND_ISSUE: begin
                state_next = ST_FIND_CHECK;
            end
            ST_FIND_CHECK: begin
                state_next = ST_FIND_ISSUE;
                if (rdata_reg != cur_reg) begin
                    cur_next = rdata_reg;
                end else if (!which_reg) begin
                    rx_next    = cur_reg;
                    which_next = 1'b1;
                    cur_next   = slot_of(ops_cur.y, entry_reg);
                end else begin
                    // both roots known: cur_reg is the root of y
                    which_next = 1'b0;
                    if (step_reg < STEP_FIRST_JOIN && rx_reg == cur_reg) begin
                        bad_next   = 1'b1;
                        state_next = ST_RESULT;
                    end else begin
                        if (step_reg >= STEP_FIRST_JOIN && rx_reg != cur_reg) begin
                            we    = 1'b1;
                            waddr = rx_reg;
                            wdata = cur_reg;
                        end
                        if (step_done) begin
                            state_next = ST_RESULT;
                        end else begin
                            step_next = step_after;
                            cur_next  = slot_of(ops_after.x, entry_reg);
                        end
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    if (bad_reg && count_reg != 32'hFFFF_FFFF) begin
                        count_next = count_reg + 32'd1;
                    end
                    m_valid_next            = 1'b1;
                    m_data_next.is_false    = bad_reg;
                    m_data_next.false_count = (bad_reg && count_reg != 32'hFFFF_FFFF)
                                              ? count_reg + 32'd1 : count_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        which_reg  <= which_next;
        cur_reg    <= cur_next;
        rx_reg     <= rx_next;
        bad_reg    <= bad_next;
        m_data_reg <= m_data_next;
        entry_reg  <= entry_next;
    end

    // parent table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[cur_reg];
    end

endmodule

/* sim/tb_three_domain_union_find_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_domain_union_find_checker
// Self-checking bench for the three-domain union-find relation checker.
// ----------------------------------------------------------------------------
// Statements go in through the s_ channel and are run through a scoreboard
// that keeps its own same/prey/predator parent table, so each result word
// is checked for its false flag and running false count. A short directed
// list covers range edges, self-eating, a food-chain cycle and its
// contradictions. It also covers item-count settings of zero, one and
// above the table size. Random phases then mostly use small pools of item
// numbers, with some noise, under three sender/receiver pacing modes.
// ----------------------------------------------------------------------------
module tb_three_domain_union_find_checker;
    import tduf_pkg::*;

    localparam int MAX_ANIMALS = 4096;
    localparam int SLOT_COUNT = 3 * MAX_ANIMALS;
    localparam int POOL_SIZE = 24;
    localparam int PHASE_ITEMS = 50;
    localparam int STALL_LIMIT = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_we = 1'b0;
    logic [12:0] cfg_wdata = '0;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned item_range = MAX_ANIMALS;
    int unsigned item_pool[POOL_SIZE];
    int unsigned settings_run = 0;
    int unsigned stall_cycles = 0;

    three_domain_union_find_checker #(
        .MAX_ANIMALS(MAX_ANIMALS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    class food_chain_model;
        int unsigned parent[SLOT_COUNT];
        int unsigned item_limit;
        logic [31:0] lie_total;
        out_t verdicts[$];
        int unsigned mismatches;
        int unsigned statements;
        int unsigned false_seen;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++) begin
                parent[i] = i;
            end
            item_limit = MAX_ANIMALS;
            lie_total = '0;
            mismatches = 0;
            statements = 0;
            false_seen = 0;
        endfunction

        function void set_limit(logic [12:0] v);
            item_limit = (v > MAX_ANIMALS) ? MAX_ANIMALS : v;
        endfunction

        function int unsigned slot(int unsigned item, logic [1:0] dom);
            return int'(dom) * MAX_ANIMALS + item - 1;
        endfunction

        function int unsigned root_of(int unsigned x);
            int unsigned up;
            while (parent[x] != x) begin
                up = parent[x];
                parent[x] = parent[up];
                x = up;
            end
            return x;
        endfunction

        function void link(int unsigned x, int unsigned y);
            int unsigned rx;
            int unsigned ry;
            rx = root_of(x);
            ry = root_of(y);
            if (rx != ry) parent[rx] = ry;
        endfunction

        function void note_statement(in_t st);
            int unsigned a;
            int unsigned b;
            int unsigned sa, pa, ea, sb, pb, eb;
            logic bad;
            a = st.animal_a;
            b = st.animal_b;
            statements++;
            if (a == 0 || b == 0 || a > item_limit || b > item_limit) begin
                bad = 1'b1;
            end else if (st.command == CMD_EATS && a == b) begin
                bad = 1'b1;
            end else begin
                sa = slot(a, DOM_SAME);
                pa = slot(a, DOM_PREY);
                ea = slot(a, DOM_PRED);
                sb = slot(b, DOM_SAME);
                pb = slot(b, DOM_PREY);
                eb = slot(b, DOM_PRED);
                if (st.command == CMD_SAME) begin
                    bad = root_of(pa) == root_of(sb) || root_of(ea) == root_of(sb) ||
                          root_of(pb) == root_of(sa) || root_of(eb) == root_of(sa);
                    if (!bad) begin
                        link(sa, sb);
                        link(pa, pb);
                        link(ea, eb);
                    end
                end else begin
                    bad = root_of(sa) == root_of(sb) || root_of(ea) == root_of(sb) ||
                          root_of(pb) == root_of(sa);
                    if (!bad) begin
                        link(pa, sb);
                        link(sa, eb);
                        link(ea, pb);
                    end
                end
            end
            if (bad) false_seen++;
            if (bad && lie_total != 32'hFFFF_FFFF) lie_total++;
            verdicts.push_back(out_t'{is_false: bad, false_count: lie_total});
        endfunction

        function void check_verdict(out_t got);
            out_t want;
            if (verdicts.size() == 0) begin
                $error("result with no statement pending: is_false %0d false_count %0d",
                       got.is_false, got.false_count);
                mismatches++;
                return;
            end
            want = verdicts.pop_front();
            if (got.is_false !== want.is_false) begin
                $error("is_false mismatch: expected %0d, actual %0d",
                       want.is_false, got.is_false);
                mismatches++;
            end
            if (got.false_count !== want.false_count) begin
                $error("false_count mismatch: expected %0d, actual %0d",
                       want.false_count, got.false_count);
                mismatches++;
            end
        endfunction
    endclass

    food_chain_model model = new();

    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side: check the word, then pick next cycle's ready
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) model.check_verdict(m_data);
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles without any word moving
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("tb_three_domain_union_find_checker failed");
                $finish;
            end
        end
    end

    task automatic send_statement(in_t st);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= st;
        do @(posedge aclk); while (!s_ready);
        model.note_statement(st);
    endtask

    task automatic send_fields(logic cmd, logic [15:0] a, logic [15:0] b);
        send_statement(in_t'{command: cmd, animal_a: a, animal_b: b});
    endtask

    // only once the block has drained and sits idle
    task automatic write_item_count(logic [12:0] v);
        s_valid <= 1'b0;
        do @(posedge aclk); while (model.verdicts.size() != 0);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        model.set_limit(v);
        item_range = (v > MAX_ANIMALS) ? MAX_ANIMALS : v;
        settings_run++;
    endtask

    function automatic logic [15:0] pick_item();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return 16'($urandom_range(16'hFFFF));
        if (r < 10) return 16'd0;
        if (r < 12) return 16'(item_range + 1);
        if (item_range <= POOL_SIZE) return 16'($urandom_range(item_range, 1));
        return 16'(item_pool[$urandom_range(POOL_SIZE - 1)]);
    endfunction

    function automatic in_t random_statement();
        in_t st;
        st.command = $urandom_range(1) ? CMD_EATS : CMD_SAME;
        st.animal_a = pick_item();
        st.animal_b = ($urandom_range(99) < 6) ? st.animal_a : pick_item();
        return st;
    endfunction

    task automatic random_phase(logic [12:0] count_setting);
        write_item_count(count_setting);
        for (int i = 0; i < POOL_SIZE; i++) begin
            item_pool[i] = $urandom_range(item_range, 1);
        end
        repeat (PHASE_ITEMS) send_statement(random_statement());
    endtask

    initial begin
        logic [12:0] phase_counts[9];
        phase_counts = '{13'd6, 13'd24, 13'd3, 13'd4096, 13'd40, 13'd12,
                         13'd8191, 13'd2, 13'd17};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, at the reset item count
        send_fields(CMD_SAME, 16'd4096, 16'd1);
        send_fields(CMD_EATS, 16'd4097, 16'd1);
        send_fields(CMD_SAME, 16'd1, 16'hFFFF);
        send_fields(CMD_EATS, 16'd0, 16'd2);
        send_fields(CMD_SAME, 16'd2, 16'd0);
        send_fields(CMD_EATS, 16'd4096, 16'd4096);
        send_fields(CMD_SAME, 16'd7, 16'd7);
        // a three-way cycle is consistent, reversing any edge is not
        send_fields(CMD_EATS, 16'd1, 16'd2);
        send_fields(CMD_EATS, 16'd2, 16'd3);
        send_fields(CMD_EATS, 16'd3, 16'd1);
        send_fields(CMD_EATS, 16'd1, 16'd3);
        send_fields(CMD_SAME, 16'd2, 16'd1);
        send_fields(CMD_EATS, 16'd3, 16'd2);
        send_fields(CMD_SAME, 16'd5, 16'd6);
        send_fields(CMD_EATS, 16'd6, 16'd7);
        send_fields(CMD_SAME, 16'd5, 16'd7);

        write_item_count(13'd0);
        send_fields(CMD_SAME, 16'd1, 16'd1);
        send_fields(CMD_EATS, 16'd1, 16'd2);
        write_item_count(13'd1);
        send_fields(CMD_SAME, 16'd1, 16'd1);
        send_fields(CMD_EATS, 16'd1, 16'd1);
        send_fields(CMD_SAME, 16'd1, 16'd2);
        write_item_count(13'h1FFF);
        send_fields(CMD_SAME, 16'd4096, 16'd4096);
        send_fields(CMD_EATS, 16'd4096, 16'd4097);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 82;
                end
                1: begin
                    tx_idle_pct = 82;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int p = 0; p < 3; p++) begin
                random_phase(phase_counts[mode * 3 + p]);
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (model.verdicts.size() != 0);
        repeat (200) @(posedge aclk);

        $display("ran %0d statements, %0d of them false, across %0d item-count settings",
                 model.statements, model.false_seen, settings_run);
        $display("pacing: sender-light, receiver-light and back-to-back phases");
        if (model.mismatches == 0 && model.verdicts.size() == 0) begin
            $display("tb_three_domain_union_find_checker passed");
        end else begin
            $display("tb_three_domain_union_find_checker failed");
        end
        $finish;
    end

endmodule
